/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Concurrent checks compile away
// in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property, sampled on clk, off while rst is high
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition that must never be true
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* src/fmeg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fmeg_pkg;

   // Envelope phases
   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_DECAY   = 2'd1,
      PH_SUSTAIN = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   // Input item kinds (carried on tuser)
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_KEY  = 1'b1;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_ATTACK_RATE   = 3'd0;
   localparam logic [2:0] CSR_DECAY_RATE    = 3'd1;
   localparam logic [2:0] CSR_SUSTAIN_RATE  = 3'd2;
   localparam logic [2:0] CSR_RELEASE_RATE  = 3'd3;
   localparam logic [2:0] CSR_SUSTAIN_LEVEL = 3'd4;
   localparam logic [2:0] CSR_TOTAL_LEVEL   = 3'd5;
   localparam logic [2:0] CSR_KEY_SCALE     = 3'd6;
   localparam logic [2:0] CSR_SSG_MODE      = 3'd7;

   localparam logic [6:0] TOTAL_LEVEL_RESET = 7'd127;
   localparam logic [9:0] ATT_MAX           = 10'h3FF;
   localparam logic [9:0] SSG_CENTER        = 10'h200;
   localparam logic [9:0] SUSTAIN_TOP       = 10'h3E0;
   localparam logic [5:0] RATE_MAX          = 6'h3F;
   localparam logic [5:0] RATE_INSTANT      = 6'd62;

   // Step patterns, bit i is the increment at step i
   localparam logic [7:0] PAT_NONE    = 8'b0000_0000;
   localparam logic [7:0] PAT_QUARTER = 8'b1000_1000;
   localparam logic [7:0] PAT_HALF    = 8'b1010_1010;
   localparam logic [7:0] PAT_FIVE    = 8'b1011_1010;
   localparam logic [7:0] PAT_SIX     = 8'b1110_1110;
   localparam logic [7:0] PAT_SEVEN   = 8'b1111_1110;

   // Effective 6-bit rate from the phase's rate register and key scaling
   function automatic logic [5:0] calc_rate(
      input phase_type  ph,
      input logic [4:0] ar,
      input logic [4:0] dr,
      input logic [4:0] sr,
      input logic [3:0] rr,
      input logic [1:0] ks,
      input logic [4:0] kc
   );
      logic [4:0] r;
      logic [4:0] ksc;
      logic [6:0] sum;
      logic [5:0] res;
      unique case (ph)
         PH_ATTACK:  r = ar;
         PH_DECAY:   r = dr;
         PH_SUSTAIN: r = sr;
         PH_RELEASE: r = {rr, 1'b1};
      endcase
      ksc = kc >> (2'd3 - ks);
      sum = {1'b0, r, 1'b0} + {2'b00, ksc};
      if (r == 5'd0) begin
         res = 6'd0;
      end else if (sum > {1'b0, RATE_MAX}) begin
         res = RATE_MAX;
      end else begin
         res = sum[5:0];
      end
      return res;
   endfunction

   // Global counter mask: 2^(11 - rate/4) - 1, zero for the top rates
   function automatic logic [10:0] gate_mask(input logic [5:0] rate);
      return 11'h7FF >> rate[5:2];
   endfunction

   // Step delta for a rate and the rolling step index
   function automatic logic [2:0] delta_lookup(
      input logic [5:0] rate,
      input logic [2:0] step
   );
      logic [7:0] pat;
      logic [2:0] base;
      base = 3'd0;
      pat  = PAT_NONE;
      priority if (rate >= 6'd60) begin
         base = 3'd4;
      end else if (rate >= 6'd48) begin
         base = 3'(rate[5:2] - 4'd11);
         unique case (rate[1:0])
            2'd0: pat = PAT_NONE;
            2'd1: pat = PAT_QUARTER;
            2'd2: pat = PAT_HALF;
            2'd3: pat = PAT_SIX;
         endcase
      end else if (rate >= 6'd8) begin
         unique case (rate[1:0])
            2'd0: pat = PAT_HALF;
            2'd1: pat = PAT_FIVE;
            2'd2: pat = PAT_SIX;
            2'd3: pat = PAT_SEVEN;
         endcase
      end else if (rate >= 6'd6) begin
         pat = PAT_SIX;
      end else if (rate >= 6'd2) begin
         pat = PAT_HALF;
      end else begin
         pat = PAT_NONE;
      end
      return base + {2'b00, pat[step]};
   endfunction

endpackage

`default_nettype wire

/* src/fm_envelope_generator_ssg.sv */
// FM envelope generator (ADSR with SSG repeat/invert mode).
// Latency: the result beat is valid in the cycle after the request beat.
// Throughput: one request per cycle while rsp_tready stays high; the whole update
// is one combinational pass between the state registers and the response register.
// Reset: synchronous, active high; envelope at attack with attenuation zero,
// all rate registers zero and total level 127.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fm_envelope_generator_ssg
   import fmeg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] key_on, [5:1] key_code, [7:6] zero
   input  wire logic        req_tuser,   // [0] cmd
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [9:0] out_attenuation, [10] phase_reset,
                                         // [15:11] zero
   // register write port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   // configuration registers
   logic [4:0] attack_rate_ff;
   logic [4:0] decay_rate_ff;
   logic [4:0] sustain_rate_ff;
   logic [3:0] release_rate_ff;
   logic [3:0] sustain_level_ff;
   logic [6:0] total_level_ff;
   logic [1:0] key_scale_ff;
   logic [3:0] ssg_mode_ff;

   // envelope state
   logic [9:0]  att_ff,  att_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  cnt_ff,  cnt_in;
   logic [11:0] gc_ff,   gc_in;
   logic [2:0]  step_ff, step_in;
   logic        held_ff, held_in;
   logic        inv_ff,  inv_in;

   // response register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        key_on;
   logic [4:0]  key_code;

   logic        ssg_en, ssg_att, ssg_alt, ssg_hold;
   logic        preset;
   logic [5:0]  att_rate;
   logic        fast_attack;
   logic [1:0]  cnt_dec;
   logic [5:0]  rate;
   logic        gate;
   logic [2:0]  delta;
   logic [2:0]  delta_m1;
   logic [13:0] att_shift;
   logic [2:0]  inc_amt;
   logic [5:0]  inc;
   logic [10:0] att_wide;
   logic [9:0]  sus_thresh;
   logic [9:0]  out_base;
   logic [10:0] out_sum;
   logic [9:0]  out_att;

   assign key_on   = req_tdata[0];
   assign key_code = req_tdata[5:1];

   assign ssg_en   = ssg_mode_ff[3];
   assign ssg_att  = ssg_mode_ff[2];
   assign ssg_alt  = ssg_mode_ff[1];
   assign ssg_hold = ssg_mode_ff[0];

   // skid-free output stage: take a new beat whenever the result slot frees up
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign sus_thresh = (sustain_level_ff == 4'hF) ? SUSTAIN_TOP
                                                  : {1'b0, sustain_level_ff, 5'b0};

   // attack rate, used wherever a new attack starts
   assign att_rate    = calc_rate(PH_ATTACK, attack_rate_ff, decay_rate_ff, sustain_rate_ff,
                                  release_rate_ff, key_scale_ff, key_code);
   assign fast_attack = (att_rate >= RATE_INSTANT);

   // next-state and result for one request beat
   always_comb begin
      att_in    = att_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      gc_in     = gc_ff;
      step_in   = step_ff;
      held_in   = held_ff;
      inv_in    = inv_ff;
      preset    = 1'b0;
      cnt_dec   = 2'(cnt_ff - 2'd1);
      rate      = 6'd0;
      gate      = 1'b0;
      delta     = 3'd0;
      delta_m1  = 3'd0;
      att_shift = 14'd0;
      inc_amt   = 3'd0;
      inc       = 6'd0;
      att_wide  = 11'd0;

      if (req_tuser == CMD_KEY) begin
         // key on/off edge
         if (held_ff != key_on) begin
            held_in = key_on;
            if (key_on) begin
               phase_in = PH_ATTACK;
               if (fast_attack) begin
                  phase_in = PH_DECAY;
                  att_in   = 10'd0;
               end
               preset = 1'b1;
            end else begin
               phase_in = PH_RELEASE;
               inv_in   = 1'b0;
            end
         end
      end else begin
         // SSG repeat / hold / alternate checks
         if (ssg_en && att_ff[9]) begin
            if (ssg_alt && (!ssg_hold || !inv_ff)) begin
               inv_in = !inv_ff;
            end
            if (!ssg_alt && !ssg_hold) begin
               preset = 1'b1;
            end
            if (phase_ff != PH_ATTACK) begin
               if (phase_ff != PH_RELEASE && !ssg_hold) begin
                  phase_in = PH_ATTACK;
                  if (fast_attack) begin
                     phase_in = PH_DECAY;
                     att_in   = 10'd0;
                  end
               end else if (phase_ff == PH_RELEASE || ((!inv_in) != ssg_att)) begin
                  att_in = ATT_MAX;
               end
            end
         end

         // envelope step, once every third tick
         cnt_in = cnt_dec;
         if (cnt_dec == 2'd0) begin
            rate   = calc_rate(phase_in, attack_rate_ff, decay_rate_ff, sustain_rate_ff,
                               release_rate_ff, key_scale_ff, key_code);
            cnt_in = 2'd3;
            gate   = ((gc_ff[10:0] & gate_mask(rate)) == 11'd0);
            gc_in  = 12'(gc_ff + 12'd1);
            if (gate) begin
               delta    = delta_lookup(rate, step_ff);
               delta_m1 = 3'(delta - 3'd1);
               step_in  = 3'(step_ff + 3'd1);
               if (phase_in == PH_ATTACK) begin
                  // exponential approach toward zero
                  if (delta != 3'd0) begin
                     att_shift = {4'hF, ~att_in} << delta_m1;
                     att_in    = 10'(att_in + att_shift[13:4]);
                  end
                  if (att_in == 10'd0) begin
                     phase_in = PH_DECAY;
                  end
               end else begin
                  // linear increase, four times the step in SSG mode
                  att_wide = {1'b0, att_in};
                  if (delta != 3'd0) begin
                     inc_amt = 3'(delta_m1 + (ssg_en ? 3'd2 : 3'd0));
                     inc     = 6'd1 << inc_amt;
                     if (!ssg_en || !att_in[9]) begin
                        att_wide = 11'({1'b0, att_in} + {5'b0, inc});
                     end
                  end
                  if (phase_in == PH_DECAY && att_wide >= {1'b0, sus_thresh}) begin
                     phase_in = PH_SUSTAIN;
                  end
                  att_in = att_wide[10] ? ATT_MAX : att_wide[9:0];
               end
            end
         end
      end

      // output level: optional SSG inversion, then total level and clamp
      out_base = att_in;
      if (ssg_en && phase_in != PH_RELEASE && (inv_in != ssg_att)) begin
         out_base = 10'(SSG_CENTER - att_in);
      end
      out_sum = {1'b0, out_base} + {1'b0, total_level_ff, 3'b0};
      out_att = out_sum[10] ? ATT_MAX : out_sum[9:0];

      rsp_data_in = {5'b0, preset, out_att};
   end

   // state, configuration and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_rate_ff   <= '0;
         decay_rate_ff    <= '0;
         sustain_rate_ff  <= '0;
         release_rate_ff  <= '0;
         sustain_level_ff <= '0;
         total_level_ff   <= TOTAL_LEVEL_RESET;
         key_scale_ff     <= '0;
         ssg_mode_ff      <= '0;
         att_ff           <= '0;
         phase_ff         <= PH_ATTACK;
         cnt_ff           <= 2'd1;
         gc_ff            <= '0;
         step_ff          <= '0;
         held_ff          <= 1'b0;
         inv_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ATTACK_RATE:   attack_rate_ff   <= csr_data[4:0];
               CSR_DECAY_RATE:    decay_rate_ff    <= csr_data[4:0];
               CSR_SUSTAIN_RATE:  sustain_rate_ff  <= csr_data[4:0];
               CSR_RELEASE_RATE:  release_rate_ff  <= csr_data[3:0];
               CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_data[3:0];
               CSR_TOTAL_LEVEL:   total_level_ff   <= csr_data[6:0];
               CSR_KEY_SCALE:     key_scale_ff     <= csr_data[1:0];
               CSR_SSG_MODE:      ssg_mode_ff      <= csr_data[3:0];
            endcase
         end
         if (req_accept) begin
            att_ff       <= att_in;
            phase_ff     <= phase_in;
            cnt_ff       <= cnt_in;
            gc_ff        <= gc_in;
            step_ff      <= step_in;
            held_ff      <= held_in;
            inv_ff       <= inv_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded on every accepted beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // checks
   `ASSERT_NEVER(a_cnt_nonzero, clock, reset, cnt_ff == 2'd0)
   `ASSERT_NEVER(a_no_accept_when_full, clock, reset,
                 rsp_valid_ff && !rsp_tready && req_tready)
   `ASSERT_PROP(a_keyoff_no_preset, clock, reset,
                (req_accept && req_tuser == CMD_KEY && !key_on) |=> !rsp_tdata[10])
   `ASSERT_PROP(a_keyoff_release, clock, reset,
                (req_accept && req_tuser == CMD_KEY && !key_on && held_ff)
                |=> (phase_ff == PH_RELEASE && !inv_ff))
   `ASSERT_PROP(a_key_keeps_counter, clock, reset,
                (req_accept && req_tuser == CMD_KEY) |=> $stable(gc_ff))

endmodule

`default_nettype wire

/* sim/tb_fm_envelope_generator_ssg.sv */
`timescale 1ns / 1ps

module tb_fm_envelope_generator_ssg;
   import fmeg_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef logic [7:0] reg_set_type [8];

   // one expected response beat
   typedef struct {
      logic [9:0] level;
      logic       restart;
   } level_beat_type;

   // Envelope predictor plus the queue of levels it expects back
   class envelope_scoreboard;
      logic [4:0]  ar, dr, sr;
      logic [3:0]  rr, sl;
      logic [6:0]  tl;
      logic [1:0]  ks;
      logic [3:0]  ssg;
      logic [9:0]  att;
      phase_type   ph;
      logic [1:0]  countdown;
      logic [11:0] gcount;
      logic [2:0]  step;
      bit          held, inverted;
      level_beat_type level_q[$];
      int          errors, responses, restarts;

      function new();
         ar = 0; dr = 0; sr = 0; rr = 0; sl = 0;
         tl = TOTAL_LEVEL_RESET; ks = 0; ssg = 0;
         att = 0; ph = PH_ATTACK; countdown = 1; gcount = 0; step = 0;
         held = 0; inverted = 0;
         errors = 0; responses = 0; restarts = 0;
      endfunction

      function int pending();
         return level_q.size();
      endfunction

      function void write_register(logic [2:0] idx, logic [7:0] val);
         case (idx)
            CSR_ATTACK_RATE:   ar  = val[4:0];
            CSR_DECAY_RATE:    dr  = val[4:0];
            CSR_SUSTAIN_RATE:  sr  = val[4:0];
            CSR_RELEASE_RATE:  rr  = val[3:0];
            CSR_SUSTAIN_LEVEL: sl  = val[3:0];
            CSR_TOTAL_LEVEL:   tl  = val[6:0];
            CSR_KEY_SCALE:     ks  = val[1:0];
            CSR_SSG_MODE:      ssg = val[3:0];
            default: ;
         endcase
      endfunction

      // rate of the current phase after key scaling, saturated at 63
      function logic [5:0] effective_rate(logic [4:0] kc);
         logic [4:0]  r;
         int unsigned sum;
         case (ph)
            PH_ATTACK:  r = ar;
            PH_DECAY:   r = dr;
            PH_SUSTAIN: r = sr;
            default:    r = {rr, 1'b1};
         endcase
         if (r == 5'd0) return 6'd0;
         sum = 2 * int'(r) + (int'(kc) >> (3 - int'(ks)));
         return (sum > RATE_MAX) ? RATE_MAX : 6'(sum);
      endfunction

      // delta per rate row; bit s of the pattern adds one at step s
      function logic [2:0] step_delta(logic [5:0] rate, logic [2:0] idx);
         logic [7:0] pat;
         logic [2:0] base;
         base = 3'd0;
         pat  = 8'h00;
         if (rate >= 6'd60) begin
            base = 3'd4;
         end else if (rate >= 6'd48) begin
            base = 3'(rate[5:2] - 4'd11);
            case (rate[1:0])
               2'd0: pat = 8'h00;
               2'd1: pat = 8'h88;
               2'd2: pat = 8'hAA;
               default: pat = 8'hEE;
            endcase
         end else if (rate >= 6'd8) begin
            case (rate[1:0])
               2'd0: pat = 8'hAA;
               2'd1: pat = 8'hBA;
               2'd2: pat = 8'hEE;
               default: pat = 8'hFE;
            endcase
         end else if (rate >= 6'd6) begin
            pat = 8'hEE;
         end else if (rate >= 6'd2) begin
            pat = 8'hAA;
         end
         return base + 3'(pat[idx]);
      endfunction

      function void begin_attack(logic [4:0] kc);
         ph = PH_ATTACK;
         // instant attack at the top rates
         if (effective_rate(kc) >= RATE_INSTANT) begin
            ph  = PH_DECAY;
            att = 10'd0;
         end
      endfunction

      function logic [9:0] level_out();
         int unsigned a;
         a = att;
         if (ssg[3] && ph != PH_RELEASE && (inverted != ssg[2]))
            a = (32'h200 - a) & 32'h3FF;
         a = a + (int'(tl) << 3);
         return (a > ATT_MAX) ? ATT_MAX : 10'(a);
      endfunction

      function void advance_envelope(logic [4:0] kc);
         logic [5:0]  rate;
         logic [10:0] mask;
         logic [2:0]  d;
         int unsigned shift, inv, acc, inc, thresh;
         bit          open;
         countdown = countdown - 2'd1;
         if (countdown != 2'd0) return;
         rate = effective_rate(kc);
         countdown = 2'd3;
         shift = (rate[5:2] <= 4'd11) ? 11 - int'(rate[5:2]) : 0;
         mask = 11'((1 << shift) - 1);
         open = (gcount & {1'b0, mask}) == 12'd0;
         gcount = gcount + 12'd1;
         if (!open) return;
         d = step_delta(rate, step);
         step = step + 3'd1;
         // attack: exponential approach toward zero attenuation
         if (ph == PH_ATTACK) begin
            if (d != 3'd0) begin
               inv = ~{22'd0, att};
               acc = att + ((inv << (d - 1)) >> 4);
               att = 10'(acc);
            end
            if (att == 10'd0) ph = PH_DECAY;
            return;
         end
         // other phases: linear growth, four times faster with SSG on
         acc = att;
         if (d != 3'd0) begin
            inc = 1 << ((int'(d) - 1) + (ssg[3] ? 2 : 0));
            if (!ssg[3] || att < SSG_CENTER) acc = acc + inc;
         end
         thresh = (sl == 4'hF) ? SUSTAIN_TOP : {1'b0, sl, 5'b0};
         if (ph == PH_DECAY && acc >= thresh) ph = PH_SUSTAIN;
         att = (acc > ATT_MAX) ? ATT_MAX : 10'(acc);
      endfunction

      // predicts the response to one accepted request; returns 0 for a key
      // change that changes nothing
      function bit note_request(bit cmd, bit kon, logic [4:0] kc);
         level_beat_type exp_beat;
         bit          restart, effective;
         restart   = 1'b0;
         effective = 1'b1;
         if (cmd == CMD_KEY) begin
            if (held != kon) begin
               held = kon;
               if (kon) begin
                  begin_attack(kc);
                  restart = 1'b1;
               end else begin
                  ph = PH_RELEASE;
                  inverted = 1'b0;
               end
            end else begin
               effective = 1'b0;
            end
         end else begin
            // SSG repeat / alternate / hold once past the midpoint
            if (ssg[3] && att >= SSG_CENTER) begin
               if (ssg[1] && (!ssg[0] || !inverted)) inverted = !inverted;
               if (!ssg[1] && !ssg[0]) restart = 1'b1;
               if (ph != PH_ATTACK) begin
                  if (ph != PH_RELEASE && !ssg[0])
                     begin_attack(kc);
                  else if (ph == PH_RELEASE || ((!inverted) != ssg[2]))
                     att = ATT_MAX;
               end
            end
            advance_envelope(kc);
         end
         exp_beat.level   = level_out();
         exp_beat.restart = restart;
         level_q.push_back(exp_beat);
         return effective;
      endfunction

      function void check_response(logic [15:0] data);
         level_beat_type exp_beat;
         responses++;
         if (data[10]) restarts++;
         if (level_q.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected, actual level %0d restart %0d",
                     $time, data[9:0], data[10]);
            return;
         end
         exp_beat = level_q.pop_front();
         if (data[9:0] !== exp_beat.level) begin
            errors++;
            $display("%0t: out_attenuation mismatch, expected %0d actual %0d",
                     $time, exp_beat.level, data[9:0]);
         end
         if (data[10] !== exp_beat.restart) begin
            errors++;
            $display("%0t: phase_reset mismatch, expected %0d actual %0d",
                     $time, exp_beat.restart, data[10]);
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [7:0]  csr_data;

   envelope_scoreboard board;
   bit calm;
   int cycles = 0;
   int beats_sent = 0;
   int items_sent = 0;
   int key_beats = 0;
   int settings = 0;

   fm_envelope_generator_ssg dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   // mostly short gaps, a few long ones, none in calm stretches
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side back-pressure
   initial begin
      int stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // one request beat; entered and left at a falling edge
   task automatic send_item(input bit cmd, input bit kon, input logic [4:0] kc);
      int gap;
      bit eff;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, kc, kon};
      do @(posedge clock); while (!req_tready);
      eff = board.note_request(cmd, kon, kc);
      items_sent++;
      if (eff) beats_sent++;
      if (cmd == CMD_KEY) key_beats++;
      @(negedge clock);
   endtask

   // stop sending and let every expected beat come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // write all eight registers back to back; block must be idle
   task automatic write_registers(input reg_set_type vals);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         board.write_register(3'(i), vals[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings++;
   endtask

   function automatic logic [7:0] pick_rate();
      if ($urandom_range(0, 9) < 6) return 8'($urandom_range(22, 31));
      return 8'($urandom_range(0, 31));
   endfunction

   function automatic reg_set_type random_settings();
      reg_set_type v;
      v[CSR_ATTACK_RATE]   = pick_rate();
      v[CSR_DECAY_RATE]    = pick_rate();
      v[CSR_SUSTAIN_RATE]  = pick_rate();
      v[CSR_RELEASE_RATE]  = 8'($urandom_range(0, 15));
      v[CSR_SUSTAIN_LEVEL] = 8'($urandom_range(0, 15));
      v[CSR_TOTAL_LEVEL]   = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 15))
                                                        : 8'($urandom_range(0, 127));
      v[CSR_KEY_SCALE]     = 8'($urandom_range(0, 3));
      v[CSR_SSG_MODE]      = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8, 15))
                                                        : 8'($urandom_range(0, 7));
      return v;
   endfunction

   function automatic reg_set_type edge_settings(input bit top);
      reg_set_type v;
      v[CSR_ATTACK_RATE]   = top ? 8'd31 : 8'd0;
      v[CSR_DECAY_RATE]    = top ? 8'd31 : 8'd0;
      v[CSR_SUSTAIN_RATE]  = top ? 8'd31 : 8'd0;
      v[CSR_RELEASE_RATE]  = top ? 8'd15 : 8'd0;
      v[CSR_SUSTAIN_LEVEL] = top ? 8'd15 : 8'd0;
      v[CSR_TOTAL_LEVEL]   = 8'd0;
      v[CSR_KEY_SCALE]     = top ? 8'd3 : 8'd0;
      v[CSR_SSG_MODE]      = top ? 8'd15 : 8'd0;
      return v;
   endfunction

   initial begin
      reg_set_type vals;
      logic [4:0] kc;
      int         budget, start, nticks, left;
      bit         paused;

      board      = new();
      calm       = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_TICK;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_ATTACK_RATE;
      csr_data   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: zero rates hold the envelope, total level 127 puts the level at 1016
      send_item(CMD_KEY, 1'b0, 5'd0);          // key off while released
      send_item(CMD_TICK, 1'b0, 5'd0);
      send_item(CMD_TICK, 1'b1, 5'd31);
      send_item(CMD_KEY, 1'b1, 5'd0);          // attack with zero rate
      send_item(CMD_KEY, 1'b1, 5'd31);         // key on while held
      send_item(CMD_TICK, 1'b0, 5'd31);
      send_item(CMD_KEY, 1'b0, 5'd31);
      send_item(CMD_KEY, 1'b0, 5'd0);
      send_item(CMD_TICK, 1'b0, 5'd0);
      drain();

      // top rates without SSG: instant attack, then decay and release
      vals = edge_settings(1'b1);
      vals[CSR_SSG_MODE] = 8'd0;
      write_registers(vals);
      send_item(CMD_KEY, 1'b1, 5'd31);
      repeat (6) send_item(CMD_TICK, 1'b0, 5'd31);
      send_item(CMD_KEY, 1'b0, 5'd0);
      repeat (4) send_item(CMD_TICK, 1'b1, 5'd0);
      send_item(CMD_KEY, 1'b1, 5'd16);
      drain();

      // random phases, each under its own register setting
      for (int p = 0; p < 12; p++) begin
         if (p == 0) vals = edge_settings(1'b0);
         else if (p == 1) vals = edge_settings(1'b1);
         else vals = random_settings();
         write_registers(vals);
         calm   = ($urandom_range(0, 3) == 0);
         budget = 95;
         start  = items_sent;
         paused = 1'b0;
         while (items_sent - start < budget) begin
            left = budget - (items_sent - start);
            if ($urandom_range(0, 99) < 85) begin
               // note: key on, ticks, key off, release ticks
               kc = 5'($urandom_range(0, 31));
               send_item(CMD_KEY, 1'b1, kc);
               nticks = $urandom_range(10, 160);
               if (nticks > left) nticks = left;
               repeat (nticks) begin
                  if ($urandom_range(0, 9) < 3) kc = 5'($urandom_range(0, 31));
                  send_item(CMD_TICK, 1'($urandom_range(0, 1)), kc);
               end
               send_item(CMD_KEY, 1'b0, 5'($urandom_range(0, 31)));
               nticks = $urandom_range(5, 40);
               repeat (nticks) send_item(CMD_TICK, 1'($urandom_range(0, 1)), kc);
               if (!paused) begin
                  drain();
                  paused = 1'b1;
               end
            end else begin
               // noise: any mix of kinds and keys
               repeat ($urandom_range(1, 6))
                  send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            5'($urandom_range(0, 31)));
            end
         end
         drain();
      end

      calm = 1'b0;
      drain();
      repeat (8) @(negedge clock);
      if (board.pending() != 0) begin
         board.errors++;
         $display("%0t: %0d expected beats never arrived", $time, board.pending());
      end

      $display("Covered %0d request beats (%0d effective, %0d key) over %0d register settings",
               items_sent, beats_sent, key_beats, settings);
      $display("Checked %0d response beats, %0d with phase reset; %0d mismatches",
               board.responses, board.restarts, board.errors);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
